[design/tbt_pkg.sv]
// Package for the triangle tangent/bitangent unit: command and status types,
// fixed-point constants and the texture coordinate input helper.
// No dependencies.
package tbt_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned DIFF_W    = 33;
    localparam int unsigned PROD_W    = 66;
    localparam int unsigned ACC_W     = 67;
    localparam int unsigned REM_W     = 82;
    localparam int unsigned DSH_W     = 97;
    localparam int unsigned QUO_W     = 31;
    localparam int unsigned NUM_RES   = 6;
    localparam int unsigned IN_W      = 5 * WORD_W;
    localparam int unsigned OUT_W     = NUM_RES * WORD_W;

    localparam logic [3:0] TERM_DET_LAST = 4'd1;
    localparam logic [3:0] TERM_LAST     = 4'd13;
    localparam logic [4:0] DIV_LAST_STEP = 5'd30;

    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;

    localparam logic signed [WORD_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef struct packed {
        logic       ld_first;
        logic       ld_second;
        logic       ld_cur;
        logic       ld_ops;
        logic       mul;
        logic       acc;
        logic       det_save;
        logic       div_start;
        logic       sat_chk;
        logic       div_step;
        logic       store;
        logic       publish;
        logic [3:0] term;
    } tbt_cmd_t;

    typedef struct packed {
        logic acc_zero;
        logic sat;
    } tbt_stat_t;

    // Applies the optional 1.0 - t inversion; only positive overflow can occur.
    function automatic logic [WORD_W-1:0] tex_take(input logic [WORD_W-1:0] raw,
                                                   input logic inv);
        logic signed [WORD_W:0] t;
        t = {ONE_Q16[WORD_W-1], ONE_Q16} - {raw[WORD_W-1], raw};
        if (!inv)
            return raw;
        else if (t > $signed({2'b00, SAT_POS[WORD_W-2:0]}))
            return SAT_POS;
        else
            return t[WORD_W-1:0];
    endfunction

endpackage

[design/tbt_datapath.sv]
// Datapath of the tangent/bitangent unit: vertex registers, edge differences,
// shared multiplier and accumulator, restoring divider and result registers.
// Depends on tbt_pkg.
module tbt_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  tbt_pkg::tbt_cmd_t         cmd,
    output tbt_pkg::tbt_stat_t        stat,
    input  logic                      cfg_we,
    input  logic                      cfg_data,
    input  logic [tbt_pkg::IN_W-1:0]  in_data,
    output logic [tbt_pkg::OUT_W-1:0] out_data,
    output logic                      out_degen
);
    import tbt_pkg::*;

    logic                       invert_reg;
    logic [WORD_W-1:0]          first_pos_reg [3];
    logic [WORD_W-1:0]          first_tex_reg [2];
    logic [WORD_W-1:0]          second_pos_reg [3];
    logic [WORD_W-1:0]          second_tex_reg [2];
    logic [WORD_W-1:0]          cur_pos_reg [3];
    logic [WORD_W-1:0]          cur_tex_reg [2];
    logic [WORD_W-1:0]          in_pos [3];
    logic [WORD_W-1:0]          in_tex [2];
    logic signed [DIFF_W-1:0]   e1 [3];
    logic signed [DIFF_W-1:0]   e2 [3];
    logic signed [DIFF_W-1:0]   du1, dv1, du2, dv2;
    logic signed [DIFF_W-1:0]   opa_next, opb_next;
    logic signed [DIFF_W-1:0]   opa_reg, opb_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    det_reg;
    logic signed [ACC_W-1:0]    acc_mag, det_mag;
    logic [REM_W-1:0]           rem_reg;
    logic [DSH_W-1:0]           dsh_reg;
    logic [DSH_W-1:0]           dsh_half;
    logic [QUO_W-1:0]           q_reg;
    logic                       neg_reg;
    logic                       sat_reg;
    logic                       step_ge;
    logic [WORD_W-1:0]          q_signed;
    logic [WORD_W-1:0]          store_val;
    logic [WORD_W-1:0]          res_reg [NUM_RES];
    logic [WORD_W-1:0]          out_res_reg [NUM_RES];
    logic                       out_degen_reg;
    logic [2:0]                 pair;
    logic [2:0]                 res_idx;
    logic [1:0]                 lane;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_pos[i] = in_data[i*WORD_W +: WORD_W];
        end
        in_tex[0] = tex_take(in_data[3*WORD_W +: WORD_W], invert_reg);
        in_tex[1] = tex_take(in_data[4*WORD_W +: WORD_W], invert_reg);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = $signed({second_pos_reg[i][WORD_W-1], second_pos_reg[i]})
                  - $signed({first_pos_reg[i][WORD_W-1], first_pos_reg[i]});
            e2[i] = $signed({cur_pos_reg[i][WORD_W-1], cur_pos_reg[i]})
                  - $signed({first_pos_reg[i][WORD_W-1], first_pos_reg[i]});
        end
        du1 = $signed({second_tex_reg[0][WORD_W-1], second_tex_reg[0]})
            - $signed({first_tex_reg[0][WORD_W-1], first_tex_reg[0]});
        dv1 = $signed({second_tex_reg[1][WORD_W-1], second_tex_reg[1]})
            - $signed({first_tex_reg[1][WORD_W-1], first_tex_reg[1]});
        du2 = $signed({cur_tex_reg[0][WORD_W-1], cur_tex_reg[0]})
            - $signed({first_tex_reg[0][WORD_W-1], first_tex_reg[0]});
        dv2 = $signed({cur_tex_reg[1][WORD_W-1], cur_tex_reg[1]})
            - $signed({first_tex_reg[1][WORD_W-1], first_tex_reg[1]});
    end

    // Pair 0 is the determinant, pairs 1-3 the tangent, pairs 4-6 the bitangent.
    assign pair    = cmd.term[3:1];
    assign res_idx = pair - 3'd1;

    always_comb
    begin
        lane     = 2'd0;
        opa_next = du1;
        opb_next = dv2;
        case (pair)
            3'd0:
            begin
                opa_next = cmd.term[0] ? du2 : du1;
                opb_next = cmd.term[0] ? dv1 : dv2;
            end
            3'd1, 3'd2, 3'd3:
            begin
                lane     = 2'(pair - 3'd1);
                opa_next = cmd.term[0] ? dv1 : dv2;
                opb_next = cmd.term[0] ? e2[lane] : e1[lane];
            end
            3'd4, 3'd5, 3'd6:
            begin
                lane     = 2'(pair - 3'd4);
                opa_next = cmd.term[0] ? du2 : du1;
                opb_next = cmd.term[0] ? e1[lane] : e2[lane];
            end
            default:
            begin
                lane = 2'd0;
            end
        endcase
    end

    assign acc_mag  = acc_reg[ACC_W-1] ? -acc_reg : acc_reg;
    assign det_mag  = det_reg[ACC_W-1] ? -det_reg : det_reg;
    assign dsh_half = dsh_reg >> 1;
    assign step_ge  = {{(DSH_W-REM_W){1'b0}}, rem_reg} >= dsh_half;
    assign q_signed = neg_reg ? (WORD_W'(0) - {1'b0, q_reg}) : {1'b0, q_reg};
    assign store_val = sat_reg ? (neg_reg ? SAT_NEG : SAT_POS) : q_signed;

    assign stat.acc_zero = (acc_reg == '0);
    assign stat.sat      = {{(DSH_W-REM_W){1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            invert_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_first)
        begin
            first_pos_reg <= in_pos;
            first_tex_reg <= in_tex;
        end
        if (cmd.ld_second)
        begin
            second_pos_reg <= in_pos;
            second_tex_reg <= in_tex;
        end
        if (cmd.ld_cur)
        begin
            cur_pos_reg <= in_pos;
            cur_tex_reg <= in_tex;
        end
        if (cmd.ld_ops)
        begin
            opa_reg <= opa_next;
            opb_reg <= opb_next;
        end
        if (cmd.mul)
        begin
            prod_reg <= opa_reg * opb_reg;
        end
        if (cmd.acc)
        begin
            if (cmd.term[0])
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            else
                acc_reg <= ACC_W'(prod_reg);
        end
        if (cmd.det_save)
        begin
            det_reg <= acc_reg;
        end
        if (cmd.div_start)
        begin
            neg_reg <= acc_reg[ACC_W-1] ^ det_reg[ACC_W-1];
            rem_reg <= {acc_mag[PROD_W-1:0], 16'b0};
            dsh_reg <= {det_mag[PROD_W-1:0], 31'b0};
            q_reg   <= '0;
        end
        if (cmd.sat_chk)
        begin
            sat_reg <= stat.sat;
        end
        if (cmd.div_step)
        begin
            dsh_reg <= dsh_half;
            q_reg   <= {q_reg[QUO_W-2:0], step_ge};
            if (step_ge)
                rem_reg <= rem_reg - dsh_half[REM_W-1:0];
        end
        if (cmd.store)
        begin
            res_reg[res_idx] <= store_val;
        end
        if (cmd.publish)
        begin
            out_degen_reg <= (det_reg == '0);
            for (int i = 0; i < NUM_RES; i++)
            begin
                out_res_reg[i] <= (det_reg == '0) ? '0 : res_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_RES; i++)
        begin
            out_data[i*WORD_W +: WORD_W] = out_res_reg[i];
        end
    end

    assign out_degen = out_degen_reg;

endmodule

[design/tbt_ctrl.sv]
// Controller of the tangent/bitangent unit: vertex slot, term and divide
// sequencing, and the input and output handshakes.
// Depends on tbt_pkg.
module tbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tbt_pkg::tbt_stat_t  stat,
    output tbt_pkg::tbt_cmd_t   cmd
);
    import tbt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_LOAD  = 10'b00_0000_0010,
        ST_MUL   = 10'b00_0000_0100,
        ST_ACC   = 10'b00_0000_1000,
        ST_CHK   = 10'b00_0001_0000,
        ST_DST   = 10'b00_0010_0000,
        ST_DSAT  = 10'b00_0100_0000,
        ST_DIV   = 10'b00_1000_0000,
        ST_STORE = 10'b01_0000_0000,
        ST_OUT   = 10'b10_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic [3:0] term_reg, term_next;
    logic [4:0] bit_reg, bit_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_acc;
    logic       can_publish;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign can_publish = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        term_next      = term_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.term       = term_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (slot_reg)
                        SLOT_SECOND:
                        begin
                            cmd.ld_second = 1'b1;
                            slot_next     = SLOT_THIRD;
                        end
                        SLOT_THIRD:
                        begin
                            cmd.ld_cur = 1'b1;
                            slot_next  = SLOT_FIRST;
                            term_next  = '0;
                            state_next = ST_LOAD;
                        end
                        default:
                        begin
                            cmd.ld_first = 1'b1;
                            slot_next    = SLOT_SECOND;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.ld_ops = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (!term_reg[0])
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = ST_LOAD;
                end
                else if (term_reg == TERM_DET_LAST)
                    state_next = ST_CHK;
                else
                    state_next = ST_DST;
            end
            ST_CHK:
            begin
                cmd.det_save = 1'b1;
                if (stat.acc_zero)
                    state_next = ST_OUT;
                else
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_DST:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DSAT;
            end
            ST_DSAT:
            begin
                cmd.sat_chk = 1'b1;
                bit_next    = '0;
                state_next  = stat.sat ? ST_STORE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_next     = bit_reg + 5'd1;
                if (bit_reg == DIV_LAST_STEP)
                    state_next = ST_STORE;
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (term_reg == TERM_LAST)
                    state_next = ST_OUT;
                else
                begin
                    term_next  = term_reg + 4'd1;
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (can_publish)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= SLOT_FIRST;
            term_reg      <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            term_reg      <= term_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_slot_valid: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg != 2'd3)
        else $error("vertex slot reached an unused code");

    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && slot_reg == SLOT_THIRD) |=> (state_reg == ST_LOAD))
        else $error("third vertex did not start the computation");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        term_reg <= TERM_LAST)
        else $error("term counter out of range");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result published over an untaken word");
`endif

endmodule

[design/triangle_tangent_bitangent.sv]
// Top level of the triangle tangent/bitangent unit: stream ports and the
// controller and datapath instances. Depends on tbt_pkg, tbt_ctrl, tbt_datapath.
//
//   channel   direction  handshake                     payload
//   s_axis    in         s_axis_tvalid/s_axis_tready   vertex position and texcoord
//   m_axis    out        m_axis_tvalid/m_axis_tready   tangent, bitangent, degenerate
//   cfg       in         cfg_valid/cfg_ready           invert_tex
//
// The first two vertex words of a triangle are only stored. The third word
// starts the shared multiplier and divider: two products and a zero check for
// the determinant, then for each component two products, a divide set-up, the
// one-bit-per-cycle restoring divider (skipped when it saturates) and a store,
// and then the publish; a zero determinant skips the components and goes
// straight to the publish.
// Reset clears the vertex slot, the controller and invert_tex. A finished
// result waits in the output register while the next vertices are accepted;
// only a second finished triangle waits for m_axis_tready.
module triangle_tangent_bitangent (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: pos_x, pos_y, pos_z, tex_u, tex_v (32 bits each).
    input  logic [tbt_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // Fields from bit 0: tangent_x, tangent_y, tangent_z,
    // bitangent_x, bitangent_y, bitangent_z (32 bits each).
    output logic [tbt_pkg::OUT_W-1:0]   m_axis_tdata,
    // Field: degenerate.
    output logic                        m_axis_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import tbt_pkg::*;

    tbt_cmd_t  cmd;
    tbt_stat_t stat;

    // Always taken, so configuration must be written only while the unit is idle.
    assign cfg_ready = 1'b1;

    tbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tbt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_data  (m_axis_tdata),
        .out_degen (m_axis_tuser)
    );

endmodule
